// ===== rtl/dtmf_pkg.sv =====
`default_nettype none

package dtmf_pkg;

	localparam int SINE_LOG2        = 8;
	localparam int SINE_TABLE_DEPTH = 1 << SINE_LOG2;
	localparam int SAMPLE_BITS      = 8;
	localparam int IDX_W            = SINE_LOG2 + 2;
	localparam int TAB_W            = SINE_LOG2 + 1;
	localparam int DIV_W            = 27;
	localparam int DIV_CNT_W        = $clog2(DIV_W + 1);
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

	localparam logic [15:0] MS_PER_S = 16'd1000;

	// floor(x / 1000) as (x * LEN_RECIP) >> LEN_SHIFT, exact for x below 2^26
	localparam int          LEN_SHIFT = 36;
	localparam logic [26:0] LEN_RECIP = 27'(((64'd1 << LEN_SHIFT) + 64'(MS_PER_S) - 64'd1)
		/ 64'(MS_PER_S));

	typedef enum logic [1:0] {
		REG_SAMPLE_RATE = 2'd0,
		REG_TONE_MS     = 2'd1,
		REG_GAP_SAMPLES = 2'd2,
		REG_GAP_ENABLE  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] key_char;
	} cmd_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   sample_valid;
		logic                   last;
		logic                   key_ok;
	} smp_t;

	typedef struct packed {
		logic [15:0] sample_rate;
		logic [9:0]  tone_ms;
		logic [15:0] gap_samples;
		logic        gap_enable;
	} cfg_t;

	typedef enum logic [1:0] {
		KIND_KEY,
		KIND_SPACE,
		KIND_BAD
	} key_kind_t;

	// classified command as it sits in the queue
	typedef struct packed {
		logic      tick;
		key_kind_t kind;
		logic [1:0] col;
		logic [1:0] row;
	} item_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [15:0]      divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_TONE,
		MODE_GAP
	} seg_mode_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_WAVE,
		B_MIX,
		B_EMIT
	} back_state_t;

	typedef enum logic [1:0] {
		DIV_COL,
		DIV_ROW,
		DIV_LEN
	} div_phase_t;

	function automatic logic [10:0] col_hz(input logic [1:0] sel);
		logic [10:0] hz;
		case (sel)
			2'd0:    hz = 11'd1209;
			2'd1:    hz = 11'd1336;
			2'd2:    hz = 11'd1477;
			default: hz = 11'd1633;
		endcase
		return hz;
	endfunction

	function automatic logic [10:0] row_hz(input logic [1:0] sel);
		logic [10:0] hz;
		case (sel)
			2'd0:    hz = 11'd697;
			2'd1:    hz = 11'd770;
			2'd2:    hz = 11'd852;
			default: hz = 11'd941;
		endcase
		return hz;
	endfunction

	// quarter-wave sine table, unsigned Q0.15, built at elaboration from a Q30 Taylor series
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DEN [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156};

	typedef logic [14:0] sine_tab_t [SINE_TABLE_DEPTH+1];

	function automatic logic [14:0] quarter_entry(input int k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned r;
		longint          acc;
		int              n;
		x    = HALF_PI_Q30 * longint'(k) / SINE_TABLE_DEPTH;
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DEN[n];
			if (n[0])
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		r = (longint'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (r > 64'd32767)
			r = 64'd32767;
		return r[14:0];
	endfunction

	function automatic sine_tab_t build_sine();
		sine_tab_t t;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
			t[k] = quarter_entry(k);
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

endpackage

`default_nettype wire

// ===== rtl/dtmf_front.sv =====
`default_nettype none

module dtmf_front (
	input  wire logic          cmd_valid,
	input  wire dtmf_pkg::cmd_t cmd,
	output logic               cmd_stall,
	input  wire logic          q_full,
	output logic               push,
	output dtmf_pkg::item_t    entry
);
	import dtmf_pkg::*;

	function automatic item_t classify(input cmd_t c);
		item_t      it;
		logic [7:0] ch;
		it.tick = c.opcode;
		it.kind = KIND_KEY;
		it.col  = 2'd0;
		it.row  = 2'd0;
		ch      = c.key_char;
		// lower-case a-d play the same keys as A-D
		if (c.key_char inside {["a":"d"]})
			ch = c.key_char - 8'd32;
		case (ch)
			"1": begin it.col = 2'd0; it.row = 2'd0; end
			"2": begin it.col = 2'd1; it.row = 2'd0; end
			"3": begin it.col = 2'd2; it.row = 2'd0; end
			"A": begin it.col = 2'd3; it.row = 2'd0; end
			"4": begin it.col = 2'd0; it.row = 2'd1; end
			"5": begin it.col = 2'd1; it.row = 2'd1; end
			"6": begin it.col = 2'd2; it.row = 2'd1; end
			"B": begin it.col = 2'd3; it.row = 2'd1; end
			"7": begin it.col = 2'd0; it.row = 2'd2; end
			"8": begin it.col = 2'd1; it.row = 2'd2; end
			"9": begin it.col = 2'd2; it.row = 2'd2; end
			"C": begin it.col = 2'd3; it.row = 2'd2; end
			"*": begin it.col = 2'd0; it.row = 2'd3; end
			"0": begin it.col = 2'd1; it.row = 2'd3; end
			"#": begin it.col = 2'd2; it.row = 2'd3; end
			"D": begin it.col = 2'd3; it.row = 2'd3; end
			" ": it.kind = KIND_SPACE;
			default: it.kind = KIND_BAD;
		endcase
		return it;
	endfunction

	assign cmd_stall = q_full;
	assign push      = cmd_valid && !q_full;
	assign entry     = classify(cmd);

endmodule

`default_nettype wire

// ===== rtl/dtmf_fifo.sv =====
`default_nettype none

module dtmf_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire dtmf_pkg::item_t wdata,
	input  wire logic            pop,
	output dtmf_pkg::item_t      rdata,
	output logic                 empty,
	output logic                 full
);
	import dtmf_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

endmodule

`default_nettype wire

// ===== rtl/dtmf_div.sv =====
`default_nettype none

module dtmf_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dtmf_pkg::div_req_t req,
	output dtmf_pkg::div_rsp_t      rsp
);
	import dtmf_pkg::*;

	logic [DIV_W-1:0]     dvd_q;
	logic [15:0]          dvs_q;
	logic [15:0]          rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [16:0]          rem_shift;
	logic [16:0]          diff;
	logic                 ge;

	// restoring division, one quotient bit per cycle shifted into the dividend register
	assign rem_shift = {rem_q, dvd_q[DIV_W-1]};
	assign ge        = (rem_shift >= {1'b0, dvs_q});
	assign diff      = rem_shift - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1)) && !req.start;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[15:0] : rem_shift[15:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

`default_nettype wire

// ===== rtl/dtmf_back.sv =====
`default_nettype none

module dtmf_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dtmf_pkg::cfg_t     cfg,
	input  wire dtmf_pkg::item_t    head,
	input  wire logic               empty,
	output logic                    pop,
	output dtmf_pkg::div_req_t      div_req,
	input  wire dtmf_pkg::div_rsp_t div_rsp,
	output logic                    smp_valid,
	input  wire logic               smp_stall,
	output dtmf_pkg::smp_t          smp
);
	import dtmf_pkg::*;

	back_state_t        state_q;
	back_state_t        state_d;
	div_phase_t         div_phase_q;
	seg_mode_t          mode_q;
	logic [15:0]        phase_col_q;
	logic [15:0]        phase_row_q;
	logic [15:0]        step_col_q;
	logic [15:0]        step_row_q;
	logic [15:0]        tone_left_q;
	logic [16:0]        gap_left_q;
	logic [1:0]         row_q;
	logic [25:0]        len_prod_q;
	smp_t               res_q;
	smp_t               out_q;
	logic               out_valid_q;
	logic signed [15:0] wave_col_s1;
	logic signed [15:0] wave_row_s1;

	logic        take;
	logic        is_key;
	logic        tone_run;
	logic        gap_run;
	logic        out_free;
	logic        emit;
	logic [16:0] extra;
	logic [16:0] space_gap;
	logic [25:0] len_prod;
	logic [52:0] len_mul;
	logic [16:0] len_quot;
	logic [15:0] len_sat;
	logic signed [16:0] wsum;
	logic [17:0] biased;
	logic [24:0] scaled;

	function automatic logic signed [15:0] wave(input logic [15:0] ph);
		logic [IDX_W-1:0]     idx;
		logic [1:0]           quad;
		logic [TAB_W-1:0]     fwd;
		logic [TAB_W-1:0]     tab_idx;
		logic [15:0]          mag;
		idx     = ph[15 -: IDX_W];
		quad    = idx[IDX_W-1 -: 2];
		fwd     = {1'b0, idx[SINE_LOG2-1:0]};
		tab_idx = quad[0] ? (TAB_W'(SINE_TABLE_DEPTH) - fwd) : fwd;
		mag     = {1'b0, SINE_TAB[tab_idx]};
		return signed'(quad[1] ? 16'(-mag) : mag);
	endfunction

	assign take      = (state_q == B_IDLE) && !empty;
	assign is_key    = !head.tick && (head.kind == KIND_KEY);
	assign tone_run  = (mode_q == MODE_TONE) && (tone_left_q != '0);
	assign gap_run   = (mode_q == MODE_GAP) && (gap_left_q != '0);
	assign out_free  = !out_valid_q || !smp_stall;
	assign emit      = (state_q == B_EMIT) && out_free;
	assign extra     = cfg.gap_enable ? {1'b0, cfg.gap_samples} : '0;
	assign space_gap = {1'b0, cfg.gap_samples} + extra;
	assign len_prod  = {16'b0, cfg.tone_ms} * {10'b0, cfg.sample_rate};

	// tone length = tone_ms * sample_rate / 1000 by reciprocal multiply
	assign len_mul  = {27'b0, len_prod_q} * {26'b0, LEN_RECIP};
	assign len_quot = len_mul[LEN_SHIFT +: 17];
	assign len_sat  = len_quot[16] ? 16'hFFFF : len_quot[15:0];

	// (s + 65536) * 127 >> 16 with s in Q2.15
	assign wsum   = 17'(wave_col_s1) + 17'(wave_row_s1);
	assign biased = {wsum[16], wsum} + 18'h10000;
	assign scaled = {biased, 7'b0} - {7'b0, biased};

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					if (is_key)
						state_d = B_DIV;
					else if (head.tick && tone_run)
						state_d = B_WAVE;
					else
						state_d = B_EMIT;
				end
			end
			B_DIV: begin
				if (div_phase_q == DIV_LEN)
					state_d = B_EMIT;
			end
			B_WAVE: state_d = B_MIX;
			B_MIX:  state_d = B_EMIT;
			B_EMIT: begin
				if (out_free)
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop              = take;
		div_req.start    = 1'b0;
		div_req.dividend = {col_hz(head.col), 16'b0};
		div_req.divisor  = cfg.sample_rate;
		if (take && is_key) begin
			div_req.start = 1'b1;
		end else if ((state_q == B_DIV) && div_rsp.done) begin
			case (div_phase_q)
				DIV_COL: begin
					div_req.start    = 1'b1;
					div_req.dividend = {row_hz(row_q), 16'b0};
				end
				default: div_req.start = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			div_phase_q <= DIV_COL;
			mode_q      <= MODE_IDLE;
			phase_col_q <= '0;
			phase_row_q <= '0;
			step_col_q  <= '0;
			step_row_q  <= '0;
			tone_left_q <= '0;
			gap_left_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!smp_stall)
				out_valid_q <= 1'b0;

			if (take) begin
				if (!head.tick) begin
					phase_col_q <= '0;
					phase_row_q <= '0;
					tone_left_q <= '0;
					div_phase_q <= DIV_COL;
					case (head.kind)
						KIND_KEY: begin
							gap_left_q <= extra;
							mode_q     <= MODE_IDLE;
						end
						KIND_SPACE: begin
							gap_left_q <= space_gap;
							mode_q     <= (space_gap != '0) ? MODE_GAP : MODE_IDLE;
						end
						default: begin
							gap_left_q <= extra;
							mode_q     <= (extra != '0) ? MODE_GAP : MODE_IDLE;
						end
					endcase
				end else if (tone_run) begin
					// tone samples advance in the lookup cycle
				end else if (gap_run) begin
					gap_left_q <= gap_left_q - 1'b1;
					if (gap_left_q == 17'd1)
						mode_q <= MODE_IDLE;
				end else begin
					mode_q <= MODE_IDLE;
				end
			end

			if (state_q == B_WAVE) begin
				phase_col_q <= phase_col_q + step_col_q;
				phase_row_q <= phase_row_q + step_row_q;
				tone_left_q <= tone_left_q - 1'b1;
				if (tone_left_q == 16'd1)
					mode_q <= (gap_left_q != '0) ? MODE_GAP : MODE_IDLE;
			end

			if ((state_q == B_DIV) && div_rsp.done) begin
				case (div_phase_q)
					DIV_COL: begin
						step_col_q  <= div_rsp.quotient[15:0];
						div_phase_q <= DIV_ROW;
					end
					DIV_ROW: begin
						step_row_q  <= div_rsp.quotient[15:0];
						div_phase_q <= DIV_LEN;
					end
					default: ;
				endcase
			end

			if ((state_q == B_DIV) && (div_phase_q == DIV_LEN)) begin
				tone_left_q <= len_sat;
				if (len_sat != '0)
					mode_q <= MODE_TONE;
				else if (gap_left_q != '0)
					mode_q <= MODE_GAP;
				else
					mode_q <= MODE_IDLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		len_prod_q <= len_prod;
		if (take) begin
			row_q              <= head.row;
			res_q.sample       <= '0;
			res_q.sample_valid <= 1'b0;
			res_q.last         <= 1'b0;
			res_q.key_ok       <= 1'b0;
			if (!head.tick) begin
				res_q.key_ok <= (head.kind != KIND_BAD);
			end else if (tone_run) begin
				res_q.sample_valid <= 1'b1;
			end else if (gap_run) begin
				res_q.sample_valid <= 1'b1;
				res_q.last         <= (gap_left_q == 17'd1);
			end
		end
		if (state_q == B_WAVE) begin
			wave_col_s1 <= wave(phase_col_q);
			wave_row_s1 <= wave(phase_row_q);
			res_q.last  <= (tone_left_q == 16'd1) && (gap_left_q == '0);
		end
		if (state_q == B_MIX)
			res_q.sample <= scaled[23:16];
		if (emit)
			out_q <= res_q;
	end

	assign smp_valid = out_valid_q;
	assign smp       = out_q;

endmodule

`default_nettype wire

// ===== rtl/dtmf_tone_generator_top.sv =====
`default_nettype none

// DTMF dual-tone generator. A command with opcode 0 starts a character: keys 0-9, A-D
// (or a-d), * and # arm a tone pair, a space arms a silent gap, anything else is
// answered with key_ok low; with gap_enable set a gap of gap_samples follows every
// character. Each command with opcode 1 returns one 8-bit sample of the running
// sequence, last marking its final sample. Every command gives exactly one
// transaction on the sample channel. Commands are classified on entry and wait in a
// four-entry queue, so the command side keeps moving while the sample side stalls
// until the queue is full. A sample tick goes through queue pop, sine table lookup,
// mix and output register; a gap or idle tick, a space and an invalid character go
// from the queue pop straight to the output register. A key start runs the shared
// restoring divider for each of its two quotients (column step, row step), then turns
// tone_ms * sample_rate into the tone length by a reciprocal multiply. Configuration
// is written through cfg_we/cfg_index/cfg_data and takes effect at the next start.
module dtmf_tone_generator_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire dtmf_pkg::cmd_t cmd,
	output logic                smp_valid,
	input  wire logic           smp_stall,
	output dtmf_pkg::smp_t      smp,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [15:0]    cfg_data
);
	import dtmf_pkg::*;

	cfg_t     cfg_q;
	logic     push;
	item_t    entry;
	item_t    head;
	logic     q_empty;
	logic     q_full;
	logic     pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_rate <= 16'd8000;
			cfg_q.tone_ms     <= 10'd250;
			cfg_q.gap_samples <= 16'd800;
			cfg_q.gap_enable  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SAMPLE_RATE: cfg_q.sample_rate <= cfg_data;
				REG_TONE_MS:     cfg_q.tone_ms     <= cfg_data[9:0];
				REG_GAP_SAMPLES: cfg_q.gap_samples <= cfg_data;
				REG_GAP_ENABLE:  cfg_q.gap_enable  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dtmf_front u_front (
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.q_full    (q_full),
		.push      (push),
		.entry     (entry)
	);

	dtmf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (pop),
		.rdata  (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	dtmf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	dtmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp)
	);

	// the end of a sequence is always an emitted sample
	a_last_has_sample: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp.last |-> smp.sample_valid)
		else $error("last flagged without a sample");

	// a start answer carries no sample and no end mark
	a_start_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp.key_ok |-> !smp.sample_valid && !smp.last)
		else $error("start transaction carries sample flags");

	// idle and start transactions (sample_valid low) give a zero sample
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && !smp.sample_valid |-> smp.sample == '0)
		else $error("nonzero sample without sample_valid");

endmodule

`default_nettype wire
